// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

  localparam int MAG_W  = 30;            // normalized magnitude width
  localparam int RAW_W  = 32;            // magnitude width before normalization
  localparam int VAL_W  = 33;            // signed working width of path terms
  localparam int SQ_W   = 2 * MAG_W;     // one squared magnitude
  localparam int SUM_W  = 64;            // sum of four squares, padded to even width
  localparam int ROOT_W = SUM_W / 2;     // norm width
  localparam int SREM_W = ROOT_W + 4;    // square root partial remainder
  localparam int DREM_W = ROOT_W + 1;    // divider partial remainder
  localparam int SH_W   = 5;             // shift amount width

  // One classified, normalized transaction handed from front to back.
  typedef struct packed {
    logic [3:0][MAG_W-1:0] mag;          // x, y, z, w magnitudes
    logic [3:0]            neg;
    logic                  degen;
  } rmq_item_t;

  function automatic logic [15:0] sat16(input logic neg, input logic [63:0] mag);
    logic [15:0] r;
    if (neg) begin
      r = (mag > 64'd32768) ? 16'h8000 : 16'((~mag) + 64'd1);
    end else begin
      r = (mag > 64'd32767) ? 16'h7fff : mag[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// Channel   Handshake            Payload
// -------   ------------------   ------------------------------------------
// input     start / busy         r00 r01 r02 r10 r11 r12 r20 r21 r22 (Q2.14)
// result    strobe (one cycle)   quat_x quat_y quat_z quat_w degenerate
//
// One transaction per clock. A result is taken after it passes the front
// registers, the queue slot, the square and sum registers, the pipelined
// square root, the four dividers and the output register.
// Reset is synchronous; busy stays high while rst is high. The receiver cannot
// stall, so the back end drains the queue every cycle and busy does not rise
// after reset.
module rotation_matrix_to_quaternion_top
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
  output logic        strobe,
  output logic [15:0] quat_x,
  output logic [15:0] quat_y,
  output logic [15:0] quat_z,
  output logic [15:0] quat_w,
  output logic        degenerate
);

  logic      full, push, pop;
  rmq_item_t f_item, q_item;

  // hold the front while the queue is full
  assign busy = rst || full;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .en(!full), .load(start && !busy),
    .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22),
    .push(push), .item(f_item)
  );

  rmq_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(f_item),
    .full(full), .pop(pop), .dout(q_item)
  );

  rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .in_valid(pop), .in_item(q_item),
    .strobe(strobe), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .quat_w(quat_w), .degenerate(degenerate)
  );

endmodule

// ===== rtl/rmq_front.sv =====
module rmq_front
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             load,
  input  logic [15:0]      r00, r01, r02, r10, r11, r12, r20, r21, r22,
  output logic             push,
  output rmq_item_t        item
);

  localparam logic signed [VAL_W-1:0] ONE = VAL_W'(64'd1 << FRAC_BITS);

  logic                        f1_valid, f2_valid;
  logic [3:0][RAW_W-1:0]       f1_mag, f2_mag;
  logic [3:0]                  f1_neg, f2_neg;
  logic                        f1_degen, f2_degen;
  logic                        f2_left;
  logic [SH_W-1:0]             f2_amt;

  logic signed [VAL_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [VAL_W-1:0] trace, rad;
  logic signed [VAL_W-1:0] v [4];
  logic [3:0][RAW_W-1:0]   mag_c;
  logic [3:0]              neg_c;
  logic [RAW_W-1:0]        mor;
  logic [SH_W-1:0]         msb;
  logic                    left_c;
  logic [SH_W-1:0]         amt_c;

  // classify: pick the path and form the unscaled quaternion terms
  always_comb begin
    a00 = VAL_W'($signed(r00)); a01 = VAL_W'($signed(r01)); a02 = VAL_W'($signed(r02));
    a10 = VAL_W'($signed(r10)); a11 = VAL_W'($signed(r11)); a12 = VAL_W'($signed(r12));
    a20 = VAL_W'($signed(r20)); a21 = VAL_W'($signed(r21)); a22 = VAL_W'($signed(r22));
    trace = a00 + a11 + a22;
    if (trace > 0) begin
      rad = trace + ONE;
      v[0] = a21 - a12; v[1] = a02 - a20; v[2] = a10 - a01; v[3] = rad;
    end else if (a00 > a11 && a00 > a22) begin
      rad = a00 - a11 - a22 + ONE;
      v[0] = rad; v[1] = a01 + a10; v[2] = a02 + a20; v[3] = a21 - a12;
    end else if (a11 > a22) begin
      rad = a11 - a00 - a22 + ONE;
      v[0] = a01 + a10; v[1] = rad; v[2] = a12 + a21; v[3] = a02 - a20;
    end else begin
      rad = a22 - a00 - a11 + ONE;
      v[0] = a02 + a20; v[1] = a12 + a21; v[2] = rad; v[3] = a10 - a01;
    end
    for (int i = 0; i < 4; i++) begin
      neg_c[i] = v[i][VAL_W-1];
      mag_c[i] = neg_c[i] ? RAW_W'(-v[i]) : RAW_W'(v[i]);
    end
  end

  // the largest magnitude and the OR of all magnitudes share their top bit
  always_comb begin
    mor = f1_mag[0] | f1_mag[1] | f1_mag[2] | f1_mag[3];
    msb = '0;
    for (int b = 0; b < RAW_W; b++) begin
      if (mor[b]) msb = SH_W'(b);
    end
    left_c = (msb < SH_W'(MAG_W - 1));
    amt_c  = left_c ? SH_W'(MAG_W - 1) - msb : msb - SH_W'(MAG_W - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= load;
      f2_valid <= f1_valid;
    end
    if (en) begin
      f1_mag   <= mag_c;
      f1_neg   <= neg_c;
      f1_degen <= (rad <= 0);
      f2_mag   <= f1_mag;
      f2_neg   <= f1_neg;
      f2_degen <= f1_degen;
      f2_left  <= left_c;
      f2_amt   <= amt_c;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      item.mag[i] = f2_left ? MAG_W'(f2_mag[i] << f2_amt) : MAG_W'(f2_mag[i] >> f2_amt);
    end
    item.neg   = f2_neg;
    item.degen = f2_degen;
  end

  assign push = f2_valid && en;

endmodule

// ===== rtl/rmq_queue.sv =====
module rmq_queue
  import rmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rmq_item_t din,
  output logic      full,
  output logic      pop,
  output rmq_item_t dout
);

  rmq_item_t  slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;

  // the back end never stalls: drain whenever something is held
  assign pop  = (count != 2'd0);
  assign full = (count == 2'd2);
  assign dout = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) slot[wr_ptr] <= din;
  end

endmodule

// ===== rtl/rmq_back.sv =====
module rmq_back
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  rmq_item_t in_item,
  output logic      strobe,
  output logic [15:0] quat_x,
  output logic [15:0] quat_y,
  output logic [15:0] quat_z,
  output logic [15:0] quat_w,
  output logic      degenerate
);

  localparam int DQ_W = FRAC_BITS + 1;          // quotient bits, q <= 2^FRAC_BITS
  localparam int NUM_W = MAG_W + FRAC_BITS + 2; // dividend width
  localparam logic [63:0] ONE_W = 64'd1 << FRAC_BITS;

  // square and sum
  logic                     sq_valid, sm_valid;
  logic [3:0][SQ_W-1:0]     sq;
  rmq_item_t                sq_item, sm_item;
  logic [SUM_W-1:0]         sm;

  // square root pipeline, one root bit per stage
  logic                     st_valid [ROOT_W];
  logic [SREM_W-1:0]        st_rem   [ROOT_W];
  logic [ROOT_W-1:0]        st_root  [ROOT_W];
  logic [SUM_W-1:0]         st_rad   [ROOT_W];
  rmq_item_t                st_item  [ROOT_W];

  // dividers, four lanes, one quotient bit per stage
  logic                     dv_valid [DQ_W];
  logic [ROOT_W-1:0]        dv_norm  [DQ_W];
  logic [3:0][DREM_W-1:0]   dv_rem   [DQ_W];
  logic [3:0][DQ_W-1:0]     dv_low   [DQ_W];
  logic [3:0][DQ_W-1:0]     dv_q     [DQ_W];
  logic [3:0]               dv_neg   [DQ_W];
  logic                     dv_degen [DQ_W];

  function automatic logic [SREM_W+ROOT_W-1:0] sqrt_step(
    input logic [SREM_W-1:0] rem, input logic [ROOT_W-1:0] root, input logic [1:0] bits);
    logic [SREM_W+1:0] r2;
    logic [SREM_W+1:0] t;
    logic [SREM_W-1:0] rn;
    logic [ROOT_W-1:0] qn;
    r2 = {rem, bits};
    t  = {(SREM_W+2-ROOT_W-2)'(0), root, 2'b01};
    if (r2 >= t) begin
      rn = SREM_W'(r2 - t);
      qn = {root[ROOT_W-2:0], 1'b1};
    end else begin
      rn = SREM_W'(r2);
      qn = {root[ROOT_W-2:0], 1'b0};
    end
    return {rn, qn};
  endfunction

  function automatic logic [DREM_W:0] div_step(
    input logic [DREM_W-1:0] rem, input logic bit_in, input logic [ROOT_W-1:0] d);
    logic [DREM_W:0] r2;
    logic [DREM_W:0] dd;
    logic            qb;
    r2 = {rem, bit_in};
    dd = {2'b00, d};
    qb = (r2 >= dd);
    if (qb) r2 = r2 - dd;
    return {DREM_W'(r2), qb};
  endfunction

  logic [SREM_W+ROOT_W-1:0] s_res [ROOT_W];
  logic [3:0][DREM_W:0]     d_res [DQ_W];
  logic [ROOT_W-1:0]        norm0;
  logic [3:0][NUM_W-1:0]    num0;

  always_comb begin
    s_res[0] = sqrt_step('0, '0, sm[SUM_W-1 -: 2]);
    for (int k = 1; k < ROOT_W; k++) begin
      s_res[k] = sqrt_step(st_rem[k-1], st_root[k-1], st_rad[k-1][SUM_W-1 -: 2]);
    end
    norm0 = st_root[ROOT_W-1];
    for (int i = 0; i < 4; i++) begin
      num0[i] = (NUM_W'(st_item[ROOT_W-1].mag[i]) << FRAC_BITS) + NUM_W'(norm0 >> 1);
      d_res[0][i] = div_step(DREM_W'(num0[i] >> DQ_W), num0[i][DQ_W-1], norm0);
      for (int j = 1; j < DQ_W; j++) begin
        d_res[j][i] = div_step(dv_rem[j-1][i], dv_low[j-1][i][DQ_W-1], dv_norm[j-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      sm_valid <= 1'b0;
      for (int k = 0; k < ROOT_W; k++) st_valid[k] <= 1'b0;
      for (int j = 0; j < DQ_W; j++) dv_valid[j] <= 1'b0;
      strobe <= 1'b0;
    end else begin
      sq_valid <= in_valid;
      sm_valid <= sq_valid;
      st_valid[0] <= sm_valid;
      for (int k = 1; k < ROOT_W; k++) st_valid[k] <= st_valid[k-1];
      dv_valid[0] <= st_valid[ROOT_W-1];
      for (int j = 1; j < DQ_W; j++) dv_valid[j] <= dv_valid[j-1];
      strobe <= dv_valid[DQ_W-1];
    end

    for (int i = 0; i < 4; i++) sq[i] <= in_item.mag[i] * in_item.mag[i];
    sq_item <= in_item;
    sm      <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]) + SUM_W'(sq[3]);
    sm_item <= sq_item;

    st_rem[0]  <= s_res[0][SREM_W+ROOT_W-1 -: SREM_W];
    st_root[0] <= s_res[0][ROOT_W-1:0];
    st_rad[0]  <= sm << 2;
    st_item[0] <= sm_item;
    for (int k = 1; k < ROOT_W; k++) begin
      st_rem[k]  <= s_res[k][SREM_W+ROOT_W-1 -: SREM_W];
      st_root[k] <= s_res[k][ROOT_W-1:0];
      st_rad[k]  <= st_rad[k-1] << 2;
      st_item[k] <= st_item[k-1];
    end

    dv_norm[0]  <= norm0;
    dv_neg[0]   <= st_item[ROOT_W-1].neg;
    dv_degen[0] <= st_item[ROOT_W-1].degen;
    for (int i = 0; i < 4; i++) begin
      dv_rem[0][i] <= d_res[0][i][DREM_W:1];
      dv_low[0][i] <= num0[i][DQ_W-1:0] << 1;
      dv_q[0][i]   <= DQ_W'(d_res[0][i][0]);
    end
    for (int j = 1; j < DQ_W; j++) begin
      dv_norm[j]  <= dv_norm[j-1];
      dv_neg[j]   <= dv_neg[j-1];
      dv_degen[j] <= dv_degen[j-1];
      for (int i = 0; i < 4; i++) begin
        dv_rem[j][i] <= d_res[j][i][DREM_W:1];
        dv_low[j][i] <= dv_low[j-1][i] << 1;
        dv_q[j][i]   <= {dv_q[j-1][i][DQ_W-2:0], d_res[j][i][0]};
      end
    end

    // saturate, or drop in the identity for a degenerate transaction
    degenerate <= dv_degen[DQ_W-1];
    if (dv_degen[DQ_W-1]) begin
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
      quat_w <= sat16(1'b0, ONE_W);
    end else begin
      quat_x <= sat16(dv_neg[DQ_W-1][0], 64'(dv_q[DQ_W-1][0]));
      quat_y <= sat16(dv_neg[DQ_W-1][1], 64'(dv_q[DQ_W-1][1]));
      quat_z <= sat16(dv_neg[DQ_W-1][2], 64'(dv_q[DQ_W-1][2]));
      quat_w <= sat16(dv_neg[DQ_W-1][3], 64'(dv_q[DQ_W-1][3]));
    end
  end

endmodule

// ===== rtl/rmq_checker.sv =====
module rmq_checker #(
  parameter int FRAC_BITS = 14
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic [15:0] quat_x,
  input logic [15:0] quat_y,
  input logic [15:0] quat_z,
  input logic        degenerate
);

  localparam int LAT = 39 + FRAC_BITS;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, LAT))
    else $error("result without a matching start");

  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !strobe)
    else $error("result right after reset");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    strobe && degenerate |-> quat_x == 16'd0 && quat_y == 16'd0 && quat_z == 16'd0)
    else $error("degenerate result is not the identity");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .degenerate(degenerate)
);
